[hdl/lzwc_pkg.sv]
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the LZW byte code compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

  localparam int CODE_W     = 16;
  localparam int SYM_W      = 7;
  localparam int DICT_DEPTH = 65536;

  localparam logic [CODE_W-1:0] ALPHABET       = 16'd128;
  localparam logic [CODE_W-1:0] DICT_LIMIT     = 16'd65535;
  localparam logic [CODE_W-1:0] WIDE_THRESHOLD = 16'd255;
  localparam logic [CODE_W-1:0] NO_CODE        = 16'hFFFF;

  // One dictionary entry: its pair and the link to the next older sibling.
  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] sibling;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Bytes of one input item, in output order.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            stream_end;
  } load_t;

endpackage

`default_nettype wire

[hdl/lzwc_if.sv]
// ----------------------------------------------------------------------------
// lzwc_if
// Valid/ready channels for input symbols and output code bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwc_sym_if;
  logic                    valid;
  logic                    ready;
  logic [lzwc_pkg::SYM_W-1:0] symbol;
  logic                    end_of_data;
  modport source (output valid, symbol, end_of_data, input ready);
  modport sink (input valid, symbol, end_of_data, output ready);
endinterface

interface lzwc_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_run;
  logic       stream_end;
  modport source (output valid, code_byte, last_of_run, stream_end, input ready);
  modport sink (input valid, code_byte, last_of_run, stream_end, output ready);
endinterface

`default_nettype wire

[hdl/lzwc_ram.sv]
// ----------------------------------------------------------------------------
// lzwc_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[hdl/lzwc_emit.sv]
// ----------------------------------------------------------------------------
// lzwc_emit
// Output stage: holds the bytes of one item and sends them one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load_valid,
  input  wire lzwc_pkg::load_t load,
  output logic               free,
  lzwc_code_if.source        codes
);

  logic            busy;
  logic [1:0]      idx;
  logic [1:0]      last;
  logic [3:0][7:0] bytes;
  logic            stream_end;
  logic            at_last;

  assign at_last           = (idx == last);
  assign free              = !busy;
  assign codes.valid       = busy;
  assign codes.code_byte   = bytes[idx];
  assign codes.last_of_run = at_last;
  assign codes.stream_end  = at_last && stream_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (!busy && load_valid) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && codes.ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && load_valid) begin
      bytes      <= load.bytes;
      last       <= 2'(load.count - 3'd1);
      stream_end <= load.stream_end;
    end
  end

endmodule

`default_nettype wire

[hdl/lzw_byte_code_compressor.sv]
// ----------------------------------------------------------------------------
// lzw_byte_code_compressor
// LZW compressor over 7-bit symbols producing one- or two-byte codes.
// ----------------------------------------------------------------------------
// One symbol is taken at a time. A symbol that starts a prefix goes through
// S_FINISH and S_LOAD; any other through S_HEAD, then S_ENTRY once per entry
// walked in the prefix's child list (127 older ones at most), since each step is a
// read of the dictionary RAM. Each item then waits until the output stage has
// sent the previous item's bytes. The dictionary is kept in two 64K-entry RAMs
// (child list heads per prefix, and entries with sibling links). After reset
// the block marks every list head empty, in state S_CLEAR, before it takes
// its first symbol. From then on a list head counts only if it points to a
// live code whose entry names that prefix, so no clearing pass is needed after
// a full dictionary or an end of data.
`default_nettype none

module lzw_byte_code_compressor (
  input  wire logic   clk,
  input  wire logic   rst,
  lzwc_sym_if.sink    symbols,
  lzwc_code_if.source codes
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_ENTRY  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;

  logic [2:0] state;
  logic [lzwc_pkg::CODE_W-1:0] prefix_code;
  logic                        prefix_present;
  logic [lzwc_pkg::CODE_W-1:0] next_code;
  logic                        wide_mode;
  logic [lzwc_pkg::CODE_W-1:0] clr_addr;

  logic [lzwc_pkg::SYM_W-1:0]  sym;
  logic                        eod;
  logic [lzwc_pkg::CODE_W-1:0] cur;
  logic                        first;
  logic [lzwc_pkg::CODE_W-1:0] head;
  logic                        a_valid;
  logic [lzwc_pkg::CODE_W-1:0] a_code;
  logic                        b_valid;
  logic [lzwc_pkg::CODE_W-1:0] b_code;
  logic                        wide_snap;

  logic                        fc_we;
  logic [lzwc_pkg::CODE_W-1:0] fc_addr;
  logic [lzwc_pkg::CODE_W-1:0] fc_wdata;
  logic [lzwc_pkg::CODE_W-1:0] fc_rdata;
  logic                        en_we;
  logic [lzwc_pkg::CODE_W-1:0] en_addr;
  lzwc_pkg::entry_t            en_wdata;
  lzwc_pkg::entry_t            en_rdata;

  logic                        accept;
  logic [lzwc_pkg::SYM_W-1:0]  sym_in;
  logic                        live;
  logic                        hit;
  logic                        miss;
  logic [lzwc_pkg::CODE_W-1:0] link;
  logic [lzwc_pkg::CODE_W-1:0] nc_inc;
  lzwc_pkg::load_t             load;
  logic                        load_valid;
  logic                        emit_free;

  assign accept         = symbols.valid && symbols.ready;
  assign symbols.ready  = (state == S_IDLE);
  assign sym_in = ({1'b0, symbols.symbol} >= 8'(lzwc_pkg::ALPHABET))
                ? 7'(lzwc_pkg::ALPHABET - 16'd1) : symbols.symbol;

  // An entry counts only if it is live in this dictionary and names the prefix.
  assign live = (cur >= lzwc_pkg::ALPHABET) && (cur < next_code) &&
                (en_rdata.prefix == prefix_code);
  assign hit  = (state == S_ENTRY) && live && (en_rdata.symbol == sym);
  assign miss = (state == S_ENTRY) && !(live && (en_rdata.symbol == sym)) &&
                !(live && (en_rdata.sibling != lzwc_pkg::NO_CODE));
  assign link = first ? (live ? cur : lzwc_pkg::NO_CODE) : head;
  assign nc_inc = next_code + 16'd1;

  always_comb begin
    fc_we    = 1'b0;
    fc_addr  = prefix_code;
    fc_wdata = next_code;
    en_we    = 1'b0;
    en_addr  = en_rdata.sibling;
    en_wdata = '{prefix: prefix_code, symbol: sym, sibling: link};
    if (state == S_CLEAR) begin
      fc_we    = 1'b1;
      fc_addr  = clr_addr;
      fc_wdata = lzwc_pkg::NO_CODE;
    end else if (state == S_HEAD) begin
      en_addr = fc_rdata;
    end else if (miss) begin
      fc_we   = 1'b1;
      en_we   = 1'b1;
      en_addr = next_code;
    end
  end

  lzwc_ram #(.WIDTH(lzwc_pkg::CODE_W), .DEPTH(lzwc_pkg::DICT_DEPTH)) u_heads (
    .clk   (clk),
    .we    (fc_we),
    .addr  (fc_addr),
    .wdata (fc_wdata),
    .rdata (fc_rdata)
  );

  lzwc_ram #(.WIDTH(lzwc_pkg::ENTRY_W), .DEPTH(lzwc_pkg::DICT_DEPTH)) u_entries (
    .clk   (clk),
    .we    (en_we),
    .addr  (en_addr),
    .wdata (en_wdata),
    .rdata (en_rdata)
  );

  always_comb begin
    load.bytes      = '0;
    load.count      = 3'd0;
    load.stream_end = b_valid;
    if (wide_snap) begin
      if (a_valid && b_valid) begin
        load.bytes = {b_code[7:0], b_code[15:8], a_code[7:0], a_code[15:8]};
        load.count = 3'd4;
      end else if (a_valid) begin
        load.bytes[1:0] = {a_code[7:0], a_code[15:8]};
        load.count      = 3'd2;
      end else if (b_valid) begin
        load.bytes[1:0] = {b_code[7:0], b_code[15:8]};
        load.count      = 3'd2;
      end
    end else begin
      if (a_valid && b_valid) begin
        load.bytes[1:0] = {b_code[7:0], a_code[7:0]};
        load.count      = 3'd2;
      end else if (a_valid) begin
        load.bytes[0] = a_code[7:0];
        load.count    = 3'd1;
      end else if (b_valid) begin
        load.bytes[0] = b_code[7:0];
        load.count    = 3'd1;
      end
    end
  end

  assign load_valid = (state == S_LOAD) && (load.count != 3'd0);

  lzwc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load       (load),
    .free       (emit_free),
    .codes      (codes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      prefix_code    <= '0;
      prefix_present <= 1'b0;
      next_code      <= lzwc_pkg::ALPHABET;
      wide_mode      <= 1'b0;
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 16'd1;
          if (clr_addr == 16'(lzwc_pkg::DICT_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            a_valid <= 1'b0;
            if (!prefix_present) begin
              prefix_code    <= {9'd0, sym_in};
              prefix_present <= 1'b1;
              state          <= S_FINISH;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          state <= S_ENTRY;
        end
        S_ENTRY: begin
          if (hit) begin
            prefix_code <= cur;
            state       <= S_FINISH;
          end else if (miss) begin
            a_valid     <= 1'b1;
            a_code      <= prefix_code;
            prefix_code <= {9'd0, sym};
            if (next_code >= lzwc_pkg::WIDE_THRESHOLD) begin
              wide_mode <= 1'b1;
            end
            next_code <= (nc_inc >= lzwc_pkg::DICT_LIMIT) ? lzwc_pkg::ALPHABET : nc_inc;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          b_valid   <= eod;
          b_code    <= prefix_code;
          wide_snap <= wide_mode;
          if (eod) begin
            prefix_code    <= '0;
            prefix_present <= 1'b0;
            next_code      <= lzwc_pkg::ALPHABET;
            wide_mode      <= 1'b0;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load.count == 3'd0 || emit_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym <= sym_in;
      eod <= symbols.end_of_data;
    end
    if (state == S_HEAD) begin
      cur   <= fc_rdata;
      first <= 1'b1;
    end else if (state == S_ENTRY) begin
      cur   <= en_rdata.sibling;
      first <= 1'b0;
      if (first) begin
        head <= live ? cur : lzwc_pkg::NO_CODE;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_next_code_range: assert property (@(posedge clk) disable iff (rst)
    next_code >= lzwc_pkg::ALPHABET && next_code < lzwc_pkg::DICT_LIMIT)
    else $error("next_code left its range");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && b_valid) |-> (!prefix_present && !wide_mode &&
      next_code == lzwc_pkg::ALPHABET))
    else $error("dictionary state not reset at end of stream");

  a_wide_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(wide_mode) |-> $past(state == S_FINISH && eod))
    else $error("two-byte mode dropped without end of stream");
`endif

endmodule

`default_nettype wire
